// ----- rtl/cslf_pkg.sv -----
// shared types, constants and helpers of the connection slot free list
package cslf_pkg;

   // number of slots in the pool, 2 to 64 (slot fields are 6 bits wide)
   localparam int SLOTS   = 64;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SLOT_W  = 6;
   localparam int TIME_W  = 48;
   localparam int LIMIT_W = 40;
   localparam int COUNT_W = 7;
   localparam int CSR_DW  = 64;
   localparam int CSR_AW  = 4;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd299000000;

   // register index, taken from paddr[3]
   localparam logic REG_IDLE_LIMIT = 1'b0;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_AGE     = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_NOFREE  = 2'd1;
   localparam logic [1:0] STAT_IGNORED = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_ALLOC_NEXT,
      ST_REL,
      ST_REL_TAIL,
      ST_AGE_RD,
      ST_AGE_CMP,
      ST_AGE_UPD,
      ST_DONE
   } state_type;

   // link of a slot whose entry was never written: the next slot, last wraps to zero
   function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
      return nxt;
   endfunction

endpackage

// ----- rtl/connection_slot_free_list_core.sv -----
// connection slot free list allocator: sequencer, state, config register and result register
//
// Request channel (req_*): one beat is an allocate, a release or an age check.
// A beat is taken when req_valid is high and req_stall is low; req_stall stays
// high from the beat until its result is loaded into the result register.
// Result channel (rsp_*): exactly one beat per request, in order, held stable
// while rsp_stall is high. The next request is taken while a result waits.
// Allocate runs ST_ALLOC, then ST_ALLOC_NEXT unless it takes the last free slot;
// release runs ST_REL, then ST_REL_TAIL unless the list was empty; an empty-list
// allocate or an ignored release goes from its first step straight to ST_DONE.
// The next beat can be taken in the cycle after the result is loaded. The single read
// and write ports of the link memory set the allocate and release steps; the age check
// reuses the one compare unit for every slot in three steps (stamp read, compare, update).
// When the receiver stalls, the finished result is held and the next request
// waits in its last step until the result register frees up.
// Reset (synchronous): every slot is free, unhealthy and linked to the next,
// the tail is the last slot and idle_limit returns to 299000000. No clearing
// pass is needed; the link memory uses one valid bit per entry.
// Config: idle_limit at APB byte address 0; user writes it only while idle, not enforced.
module connection_slot_free_list_core (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [cslf_pkg::SLOT_W-1:0]         req_slot,
   input  logic                                req_failed,
   input  logic [cslf_pkg::TIME_W-1:0]         req_now_time,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [cslf_pkg::SLOT_W-1:0]         rsp_granted_slot,
   output logic                                rsp_needs_connect,
   output logic [cslf_pkg::COUNT_W-1:0]        rsp_closed_count,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cslf_pkg::CSR_AW-1:0]         paddr,
   input  logic [cslf_pkg::CSR_DW-1:0]         pwdata,
   output logic [cslf_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);

   cslf_pkg::state_type state_ff, state_in;

   logic [cslf_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          failed_ff, failed_in;
   logic [cslf_pkg::TIME_W-1:0]   now_ff, now_in;

   logic [cslf_pkg::IDX_W-1:0]    tail_ff, tail_in;
   logic                          empty_ff, empty_in;
   logic [cslf_pkg::SLOTS-1:0]    busy_ff, busy_in;
   logic [cslf_pkg::SLOTS-1:0]    healthy_ff, healthy_in;
   logic [cslf_pkg::SLOTS-1:0]    link_vld_ff, link_vld_in;
   logic [cslf_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [cslf_pkg::IDX_W-1:0]    rd_addr_ff;

   logic [1:0]                    res_status_ff, res_status_in;
   logic [cslf_pkg::SLOT_W-1:0]   res_granted_ff, res_granted_in;
   logic                          res_need_ff, res_need_in;
   logic [cslf_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [cslf_pkg::SLOT_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic                          rsp_need_ff, rsp_need_in;
   logic [cslf_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [cslf_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   logic                          link_we;
   logic [cslf_pkg::IDX_W-1:0]    link_waddr, link_wdata, link_raddr, link_rdata;
   logic [cslf_pkg::IDX_W-1:0]    link_val;
   logic                          stamp_we;
   logic [cslf_pkg::IDX_W-1:0]    stamp_waddr, stamp_raddr;
   logic [cslf_pkg::TIME_W-1:0]   stamp_wdata, stamp_rdata;
   logic                          expired;

   logic [cslf_pkg::IDX_W-1:0]    slot_idx;
   logic                          slot_ok;
   logic                          csr_write;

   cslf_ram #(
      .WIDTH (cslf_pkg::IDX_W),
      .DEPTH (cslf_pkg::SLOTS)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   cslf_ram #(
      .WIDTH (cslf_pkg::TIME_W),
      .DEPTH (cslf_pkg::SLOTS)
   ) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (stamp_waddr),
      .wdata (stamp_wdata),
      .raddr (stamp_raddr),
      .rdata (stamp_rdata)
   );

   cslf_idle_cmp u_idle_cmp (
      .clock      (clock),
      .now_time   (now_ff),
      .stamp      (stamp_rdata),
      .idle_limit (limit_ff),
      .expired    (expired)
   );

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[3] == cslf_pkg::REG_IDLE_LIMIT) ?
                      {{(cslf_pkg::CSR_DW - cslf_pkg::LIMIT_W){1'b0}}, limit_ff} : '0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && paddr[3] == cslf_pkg::REG_IDLE_LIMIT) begin
         limit_in = pwdata[cslf_pkg::LIMIT_W-1:0];
      end
   end

   // entries never written read as their reset link
   assign link_val = link_vld_ff[rd_addr_ff] ? link_rdata : cslf_pkg::link_reset(rd_addr_ff);
   assign slot_idx = slot_ff[cslf_pkg::IDX_W-1:0];
   assign slot_ok  = ({1'b0, slot_ff} < (cslf_pkg::SLOT_W + 1)'(cslf_pkg::SLOTS)) &&
                     busy_ff[slot_idx];

   assign req_stall = (state_ff != cslf_pkg::ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      failed_in      = failed_ff;
      now_in         = now_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      busy_in        = busy_ff;
      healthy_in     = healthy_ff;
      link_vld_in    = link_vld_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_need_in    = res_need_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_need_in    = rsp_need_ff;
      rsp_count_in   = rsp_count_ff;

      link_we     = 1'b0;
      link_waddr  = tail_ff;
      link_wdata  = link_val;
      link_raddr  = tail_ff;
      stamp_we    = 1'b0;
      stamp_waddr = slot_idx;
      stamp_wdata = now_ff;
      stamp_raddr = idx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         cslf_pkg::ST_IDLE: begin
            // the link of the tail is read every idle cycle, ready for the next op
            if (req_valid) begin
               slot_in        = req_slot;
               failed_in      = req_failed;
               now_in         = req_now_time;
               res_status_in  = cslf_pkg::STAT_DONE;
               res_granted_in = '0;
               res_need_in    = 1'b0;
               count_in       = '0;
               case (req_op)
                  cslf_pkg::OP_ALLOC:   state_in = cslf_pkg::ST_ALLOC;
                  cslf_pkg::OP_RELEASE: state_in = cslf_pkg::ST_REL;
                  cslf_pkg::OP_AGE: begin
                     idx_in   = '0;
                     state_in = cslf_pkg::ST_AGE_RD;
                  end
                  default:              state_in = cslf_pkg::ST_DONE;
               endcase
            end
         end
         cslf_pkg::ST_ALLOC: begin
            if (empty_ff) begin
               res_status_in = cslf_pkg::STAT_NOFREE;
               state_in      = cslf_pkg::ST_DONE;
            end else begin
               // link_val is the head, the slot after the tail
               busy_in[link_val]    = 1'b1;
               healthy_in[link_val] = 1'b1;
               res_need_in          = !healthy_ff[link_val];
               res_granted_in       = cslf_pkg::SLOT_W'(link_val);
               stamp_we             = 1'b1;
               stamp_waddr          = link_val;
               if (link_val == tail_ff) begin
                  empty_in = 1'b1;
                  state_in = cslf_pkg::ST_DONE;
               end else begin
                  link_raddr = link_val;
                  state_in   = cslf_pkg::ST_ALLOC_NEXT;
               end
            end
         end
         cslf_pkg::ST_ALLOC_NEXT: begin
            // unlink the head: tail points past it
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = link_val;
            state_in   = cslf_pkg::ST_DONE;
         end
         cslf_pkg::ST_REL: begin
            if (!slot_ok) begin
               res_status_in = cslf_pkg::STAT_IGNORED;
               state_in      = cslf_pkg::ST_DONE;
            end else begin
               if (failed_ff) begin
                  healthy_in[slot_idx] = 1'b0;
               end
               busy_in[slot_idx] = 1'b0;
               stamp_we          = 1'b1;
               link_we           = 1'b1;
               link_waddr        = slot_idx;
               if (empty_ff) begin
                  link_wdata = slot_idx;
                  tail_in    = slot_idx;
                  empty_in   = 1'b0;
                  state_in   = cslf_pkg::ST_DONE;
               end else begin
                  link_wdata = link_val;
                  state_in   = cslf_pkg::ST_REL_TAIL;
               end
            end
         end
         cslf_pkg::ST_REL_TAIL: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = slot_idx;
            // unhealthy slots go to the back of the list
            if (!healthy_ff[slot_idx]) begin
               tail_in = slot_idx;
            end
            state_in = cslf_pkg::ST_DONE;
         end
         cslf_pkg::ST_AGE_RD: begin
            state_in = cslf_pkg::ST_AGE_CMP;
         end
         cslf_pkg::ST_AGE_CMP: begin
            state_in = cslf_pkg::ST_AGE_UPD;
         end
         cslf_pkg::ST_AGE_UPD: begin
            if (expired && !busy_ff[idx_ff] && healthy_ff[idx_ff]) begin
               healthy_in[idx_ff] = 1'b0;
               if (count_ff != {cslf_pkg::COUNT_W{1'b1}}) begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (idx_ff == cslf_pkg::IDX_W'(cslf_pkg::SLOTS - 1)) begin
               state_in = cslf_pkg::ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = cslf_pkg::ST_AGE_RD;
            end
         end
         cslf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_need_in    = res_need_ff;
               rsp_count_in   = count_ff;
               state_in       = cslf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cslf_pkg::ST_IDLE;
         end
      endcase

      if (link_we) begin
         link_vld_in[link_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cslf_pkg::ST_IDLE;
         tail_ff      <= cslf_pkg::IDX_W'(cslf_pkg::SLOTS - 1);
         empty_ff     <= 1'b0;
         busy_ff      <= '0;
         healthy_ff   <= '0;
         link_vld_ff  <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= cslf_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         busy_ff      <= busy_in;
         healthy_ff   <= healthy_in;
         link_vld_ff  <= link_vld_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff        <= slot_in;
      failed_ff      <= failed_in;
      now_ff         <= now_in;
      rd_addr_ff     <= link_raddr;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_need_ff    <= res_need_in;
      count_ff       <= count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_need_ff    <= rsp_need_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_granted_ff;
   assign rsp_needs_connect = rsp_need_ff;
   assign rsp_closed_count  = rsp_count_ff;

   // an accepted beat always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != cslf_pkg::ST_IDLE))
      else $error("request beat accepted but sequencer stayed idle");

   // the head of a non-empty free list is never a busy slot
   a_head_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cslf_pkg::ST_ALLOC && !empty_ff) |-> !busy_ff[link_val])
      else $error("free list head is a busy slot");

   // only an age check reports closed slots
   a_count_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_closed_count != '0) |->
         (rsp_granted_slot == '0 && rsp_status == cslf_pkg::STAT_DONE && !rsp_needs_connect))
      else $error("closed count on a result that is not an age check");

endmodule

// ----- rtl/cslf_ram.sv -----
// generic single write port ram with registered read
module cslf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

// ----- rtl/cslf_idle_cmp.sv -----
// shared idle time compare unit, one slot per use, registered result
module cslf_idle_cmp (
   input  logic                           clock,
   input  logic [cslf_pkg::TIME_W-1:0]    now_time,
   input  logic [cslf_pkg::TIME_W-1:0]    stamp,
   input  logic [cslf_pkg::LIMIT_W-1:0]   idle_limit,
   output logic                           expired
);

   logic [cslf_pkg::TIME_W:0] diff;
   logic                      expired_in;
   logic                      expired_ff;

   always_comb begin
      diff = {1'b0, now_time} - {1'b0, stamp};
      // a borrow means time went backwards: idle time counts as zero
      expired_in = !diff[cslf_pkg::TIME_W] &&
         (diff[cslf_pkg::TIME_W-1:0] >
          {{(cslf_pkg::TIME_W - cslf_pkg::LIMIT_W){1'b0}}, idle_limit});
   end

   always_ff @(posedge clock) begin
      expired_ff <= expired_in;
   end

   assign expired = expired_ff;

endmodule
